// File: design/emgwap_pkg.sv
// Shared types and constants for the EMG window average / peak unit.
// Holds the controller state encoding, the command/status structs and widths.
// No dependencies.
package emgwap_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int LEVEL_MAX = 100;
    localparam int SCALE_MUL = 100;

    localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = $clog2(MAX_SAMPLES * LEVEL_MAX + 1);

    // sample * 100 needs 19 bits
    localparam int PROD_W = SAMPLE_W + LEVEL_W;

    localparam int DIV_N = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int DIV_M = (SAMPLE_W > COUNT_W) ? SAMPLE_W : COUNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BEST = 2'd3;

    localparam logic [SAMPLE_W-1:0] BG_THRESHOLD_RST = 12'd205;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST   = 12'd4095;
    localparam logic [TIME_W-1:0]   WINDOW_MS_RST    = 32'd15000;
    localparam logic [LEVEL_W-1:0]  INITIAL_BEST_RST = 7'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_ACCUM,
        ST_CLOSE,
        ST_AVG_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic level_zero;
        logic scale_start;
        logic level_load;
        logic accum;
        logic avg_start;
        logic close_zero;
        logic close_load;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic below_thr;
        logic div_done;
        logic close;
        logic count_zero;
    } dp_status_t;

endpackage

// File: design/emgwap_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Used for both the level scaling and the window mean. Depends on emgwap_pkg.
module emgwap_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [emgwap_pkg::DIV_N-1:0]  dividend,
    input  logic [emgwap_pkg::DIV_M-1:0]  divisor,
    output logic                          done,
    output logic [emgwap_pkg::DIV_N-1:0]  quotient
);
    import emgwap_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N-1:0]     quo_reg, quo_next;
    logic [DIV_M-1:0]     rem_reg, rem_next;
    logic [DIV_M-1:0]     divisor_reg, divisor_next;
    logic [DIV_M:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_N-1]};
    assign ge    = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_W'(DIV_N);
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_M'(trial - {1'b0, divisor_reg}) : trial[DIV_M-1:0];
            quo_next = {quo_reg[DIV_N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/emgwap_dp.sv
// Datapath: configuration registers, window accumulators, peak tracking,
// output register and the shared divider. Depends on emgwap_pkg, emgwap_div.
module emgwap_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [emgwap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [emgwap_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [emgwap_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic [emgwap_pkg::TIME_W-1:0]       s_now_ms,
    input  logic                                s_start_req,
    input  emgwap_pkg::dp_cmd_t                 cmd,
    output emgwap_pkg::dp_status_t              status,
    output logic [emgwap_pkg::LEVEL_W-1:0]      m_level,
    output logic [emgwap_pkg::LEVEL_W-1:0]      m_window_average,
    output logic [emgwap_pkg::LEVEL_W-1:0]      m_best_average,
    output logic                                m_window_done,
    output logic                                m_new_best
);
    import emgwap_pkg::*;

    logic [SAMPLE_W-1:0] thr_reg, fs_reg;
    logic [TIME_W-1:0]   win_reg;
    logic [LEVEL_W-1:0]  init_best_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   window_start_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [LEVEL_W-1:0]  last_avg_reg, best_reg, level_reg;
    logic                close_reg, done_reg, raised_reg;

    logic [LEVEL_W-1:0]  out_level_reg, out_avg_reg, out_best_reg;
    logic                out_done_reg, out_raised_reg;

    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] fs_div;
    logic [DIV_N-1:0]    div_dividend, div_quotient;
    logic [DIV_M-1:0]    div_divisor;
    logic                div_start, div_done;
    logic [TIME_W-1:0]   elapsed;
    logic [LEVEL_W-1:0]  init_best_sat, close_avg;

    assign product = PROD_W'(sample_reg) * PROD_W'(SCALE_MUL);
    assign fs_div  = (fs_reg == '0) ? SAMPLE_W'(1) : fs_reg;

    always_comb begin
        if (cmd.avg_start) begin
            div_dividend = DIV_N'(sum_reg);
            div_divisor  = DIV_M'(count_reg);
        end else begin
            div_dividend = DIV_N'(product);
            div_divisor  = DIV_M'(fs_div);
        end
    end

    assign div_start = cmd.scale_start | cmd.avg_start;

    emgwap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign elapsed       = now_reg - window_start_reg;
    assign init_best_sat = (init_best_reg > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                                 : init_best_reg;
    assign close_avg     = cmd.close_zero ? '0 : div_quotient[LEVEL_W-1:0];

    assign status.below_thr  = sample_reg <= thr_reg;
    assign status.div_done   = div_done;
    assign status.close      = close_reg;
    assign status.count_zero = count_reg == '0;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= BG_THRESHOLD_RST;
            fs_reg        <= FULL_SCALE_RST;
            win_reg       <= WINDOW_MS_RST;
            init_best_reg <= INITIAL_BEST_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BG_THRESHOLD: thr_reg       <= cfg_wdata[SAMPLE_W-1:0];
                CFG_FULL_SCALE:   fs_reg        <= cfg_wdata[SAMPLE_W-1:0];
                CFG_WINDOW_MS:    win_reg       <= cfg_wdata[TIME_W-1:0];
                CFG_INITIAL_BEST: init_best_reg <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            last_avg_reg     <= '0;
            best_reg         <= '0;
            close_reg        <= 1'b0;
            done_reg         <= 1'b0;
            raised_reg       <= 1'b0;
        end else begin
            if (cmd.capture) begin
                done_reg   <= 1'b0;
                raised_reg <= 1'b0;
                if (s_start_req) begin
                    window_start_reg <= s_now_ms;
                    sum_reg          <= '0;
                    count_reg        <= '0;
                    last_avg_reg     <= '0;
                    best_reg         <= init_best_sat;
                end
            end
            if (cmd.accum) begin
                close_reg <= elapsed > win_reg;
                if (level_reg != '0 && count_reg < COUNT_W'(MAX_SAMPLES)) begin
                    sum_reg   <= sum_reg + SUM_W'(level_reg);
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.close_zero || cmd.close_load) begin
                window_start_reg <= now_reg;
                sum_reg          <= '0;
                count_reg        <= '0;
                last_avg_reg     <= close_avg;
                done_reg         <= 1'b1;
                if (close_avg > best_reg) begin
                    best_reg   <= close_avg;
                    raised_reg <= 1'b1;
                end
            end
        end
    end

    // transaction payload and per-item working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample;
            now_reg    <= s_now_ms;
        end
        if (cmd.level_zero) begin
            level_reg <= '0;
        end else if (cmd.level_load) begin
            level_reg <= (div_quotient > DIV_N'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                            : div_quotient[LEVEL_W-1:0];
        end
        if (cmd.load_out) begin
            out_level_reg  <= level_reg;
            out_avg_reg    <= last_avg_reg;
            out_best_reg   <= best_reg;
            out_done_reg   <= done_reg;
            out_raised_reg <= raised_reg;
        end
    end

    assign m_level          = out_level_reg;
    assign m_window_average = out_avg_reg;
    assign m_best_average   = out_best_reg;
    assign m_window_done    = out_done_reg;
    assign m_new_best       = out_raised_reg;

endmodule

// File: design/emgwap_ctrl.sv
// Controller: sequences scaling, accumulation, window close and output load.
// Drives the datapath command struct. Depends on emgwap_pkg.
module emgwap_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  emgwap_pkg::dp_status_t status,
    output emgwap_pkg::dp_cmd_t    cmd
);
    import emgwap_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (status.below_thr) begin
                    cmd.level_zero = 1'b1;
                    state_next     = ST_ACCUM;
                end else begin
                    cmd.scale_start = 1'b1;
                    state_next      = ST_SCALE_WAIT;
                end
            end
            ST_SCALE_WAIT: begin
                if (status.div_done) begin
                    cmd.level_load = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (!status.close) begin
                    state_next = ST_FINISH;
                end else if (status.count_zero) begin
                    cmd.close_zero = 1'b1;
                    state_next     = ST_FINISH;
                end else begin
                    cmd.avg_start = 1'b1;
                    state_next    = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT: begin
                if (status.div_done) begin
                    cmd.close_load = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: design/emg_window_average_peak_unit.sv
// Top level of the EMG window average / peak unit.
// Joins emgwap_ctrl and emgwap_dp; depends on emgwap_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  cfg     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//  s_      | in        | s_valid / s_ready  | s_sample, s_now_ms, s_start_req
//  m_      | out       | m_valid / m_ready  | m_level, m_window_average, m_best_average,
//          |           |                    | m_window_done, m_new_best
//
// One transaction at a time: one serial divide when the sample is above background,
// plus a second divide when a non-empty window closes.
// Reset is synchronous, active low; config and window state return to defaults.
// A result waits in the output register; the next input is taken meanwhile, and the
// controller stalls only when loading a result while the previous one is still held.
module emg_window_average_peak_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [emgwap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [emgwap_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [emgwap_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic [emgwap_pkg::TIME_W-1:0]     s_now_ms,
    input  logic                              s_start_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [emgwap_pkg::LEVEL_W-1:0]    m_level,
    output logic [emgwap_pkg::LEVEL_W-1:0]    m_window_average,
    output logic [emgwap_pkg::LEVEL_W-1:0]    m_best_average,
    output logic                              m_window_done,
    output logic                              m_new_best
);
    import emgwap_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    emgwap_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    emgwap_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_sample         (s_sample),
        .s_now_ms         (s_now_ms),
        .s_start_req      (s_start_req),
        .cmd              (cmd),
        .status           (status),
        .m_level          (m_level),
        .m_window_average (m_window_average),
        .m_best_average   (m_best_average),
        .m_window_done    (m_window_done),
        .m_new_best       (m_new_best)
    );

endmodule
